>>> rtl/ils_pkg.sv
// Package for the indexed list store: capacity, widths, action and status
// codes, and the request / response structs used on the top-level ports.
// No dependencies.
package ils_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [2:0] ACT_APPEND   = 3'd0;
    localparam logic [2:0] ACT_INSERT   = 3'd1;
    localparam logic [2:0] ACT_REMOVE   = 3'd2;
    localparam logic [2:0] ACT_GET      = 3'd3;
    localparam logic [2:0] ACT_SET      = 3'd4;
    localparam logic [2:0] ACT_CONTAINS = 3'd5;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]               action;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
    } rsp_t;

endpackage

>>> rtl/indexed_list_store_top.sv
// Indexed list store: ordered list of signed 32-bit words in one
// synchronous RAM, with append, insert, remove, get, set and contains.
// Depends on ils_pkg.
//
//  channel   | signals              | handshake
//  ----------+----------------------+--------------------------------------
//  request   | start, busy, req     | taken on clk edge with start && !busy
//  response  | done, rsp            | done high one cycle, cannot be held
//
// Walks (c = count, p = index): insert from entry c - 1 down to p, remove from
// p + 1 up to c - 1, contains from 0 until a match or c - 1; other actions none.
// The walks move one entry per cycle through the single RAM read port.
// done follows the last busy cycle; a new request may be given while done
// is high. Reset clears the state, count and done only; the RAM is not cleared.
module indexed_list_store_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ils_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output ils_pkg::rsp_t rsp
);
    import ils_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_INS      = 6'b000010,
        ST_INS_LAST = 6'b000100,
        ST_REM      = 6'b001000,
        ST_GET      = 6'b010000,
        ST_SRCH     = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         scan_reg, scan_next;
    logic                     done_reg, done_next;
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] rdval_reg, rdval_next;
    logic                     found_reg, found_next;
    req_t                     req_reg;
    logic [DATA_W-1:0]        rdata_reg;

    logic [DATA_W-1:0]        mem [CAPACITY];
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic [IDX_W-1:0]         mem_raddr;

    logic                     accept;
    logic                     idx_valid;
    logic                     is_full;
    logic [CNT_W-1:0]         cnt_m1;

    assign accept    = start && (state_reg == ST_IDLE);
    assign idx_valid = {1'b0, req.index} < count_reg;
    assign is_full   = count_reg == CNT_W'(CAPACITY);
    assign cnt_m1    = count_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rdval_next  = rdval_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = scan_reg;
        mem_wdata   = rdata_reg;
        mem_raddr   = scan_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    status_next = STAT_OK;
                    rdval_next  = '0;
                    found_next  = 1'b0;
                    case (req.action)
                        ACT_APPEND:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                                status_next = STAT_FULL;
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                mem_wdata  = req.value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (!idx_valid)
                            begin
                                status_next = STAT_BAD_INDEX;
                                done_next   = 1'b1;
                            end
                            else if (is_full)
                            begin
                                status_next = STAT_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                // walk down from the last entry
                                mem_raddr  = cnt_m1[IDX_W-1:0];
                                scan_next  = cnt_m1[IDX_W-1:0];
                                state_next = ST_INS;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (!idx_valid)
                            begin
                                status_next = STAT_BAD_INDEX;
                                done_next   = 1'b1;
                            end
                            else if ({1'b0, req.index} != cnt_m1)
                            begin
                                mem_raddr  = req.index + 1'b1;
                                scan_next  = req.index + 1'b1;
                                state_next = ST_REM;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                done_next  = 1'b1;
                            end
                        end
                        ACT_GET:
                        begin
                            if (!idx_valid)
                            begin
                                status_next = STAT_BAD_INDEX;
                                rdval_next  = '1;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = req.index;
                                state_next = ST_GET;
                            end
                        end
                        ACT_SET:
                        begin
                            done_next = 1'b1;
                            if (!idx_valid)
                                status_next = STAT_BAD_INDEX;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = req.index;
                                mem_wdata = req.value;
                            end
                        end
                        ACT_CONTAINS:
                        begin
                            if (count_reg == '0)
                                done_next = 1'b1;
                            else
                            begin
                                mem_raddr  = '0;
                                scan_next  = '0;
                                state_next = ST_SRCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_INS:
            begin
                // entry read last cycle moves up one place
                mem_we    = 1'b1;
                mem_waddr = scan_reg + 1'b1;
                mem_wdata = rdata_reg;
                if (scan_reg == req_reg.index)
                    state_next = ST_INS_LAST;
                else
                begin
                    mem_raddr = scan_reg - 1'b1;
                    scan_next = scan_reg - 1'b1;
                end
            end
            ST_INS_LAST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = req_reg.index;
                mem_wdata  = req_reg.value;
                count_next = count_reg + 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_REM:
            begin
                // entry read last cycle moves down one place
                mem_we    = 1'b1;
                mem_waddr = scan_reg - 1'b1;
                mem_wdata = rdata_reg;
                if ({1'b0, scan_reg} == cnt_m1)
                begin
                    count_next = cnt_m1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_raddr = scan_reg + 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_GET:
            begin
                rdval_next = rdata_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SRCH:
            begin
                if (rdata_reg == req_reg.value)
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if ({1'b0, scan_reg} == cnt_m1)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_raddr = scan_reg + 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
        found_reg  <= found_next;
        if (accept)
            req_reg <= req;
    end

    // single-port-write, single-port-read RAM, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    assign busy            = state_reg != ST_IDLE;
    assign done            = done_reg;
    assign rsp.status      = status_reg;
    assign rsp.read_value  = rdval_reg;
    assign rsp.found       = found_reg;
    assign rsp.count       = count_reg;
    assign rsp.is_empty    = count_reg == '0;

`ifndef SYNTHESIS
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start || busy))
        else $error("done without a request in progress");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_count_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done)
        else $error("count changed without a response");

    a_busy_no_done_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy) && ($past(state_reg) == ST_INS)) |-> !done)
        else $error("response issued during insert walk");
`endif

endmodule

>>> verif/tb_indexed_list_store_top.sv
// Self-checking testbench for indexed_list_store_top: directed table, then random
// requests in mix / grow / full / shrink phases, checked against a local list model or table.
// Depends on ils_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_indexed_list_store_top;

    import ils_pkg::*;

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int MAX_REPORTS    = 10;

    typedef enum int { MODE_MIX, MODE_GROW, MODE_FULL, MODE_SHRINK } traffic_mode_t;

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t exp;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    indexed_list_store_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // local copy of the list
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len;

    rsp_t     expected_rsp [$];
    dir_row_t dir_tab [$];
    int       fail_count;
    int       quiet_cycles;
    int       burst_left;

    function automatic rsp_t predict_list(req_t r);
        rsp_t o;
        bit   in_range;
        int   i;
        o        = '0;
        in_range = int'(r.index) < list_len;
        case (r.action)
            ACT_APPEND:
                if (list_len >= CAPACITY)
                    o.status = STAT_FULL;
                else
                begin
                    list_mem[list_len] = r.value;
                    list_len++;
                end
            ACT_INSERT:
                // index is checked before fullness
                if (!in_range)
                    o.status = STAT_BAD_INDEX;
                else if (list_len >= CAPACITY)
                    o.status = STAT_FULL;
                else
                begin
                    for (i = list_len; i > int'(r.index); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[r.index] = r.value;
                    list_len++;
                end
            ACT_REMOVE:
                if (!in_range)
                    o.status = STAT_BAD_INDEX;
                else
                begin
                    for (i = int'(r.index); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            ACT_GET:
                if (!in_range)
                begin
                    o.status     = STAT_BAD_INDEX;
                    o.read_value = -1;
                end
                else
                    o.read_value = list_mem[r.index];
            ACT_SET:
                if (!in_range)
                    o.status = STAT_BAD_INDEX;
                else
                    list_mem[r.index] = r.value;
            ACT_CONTAINS:
                for (i = 0; i < list_len; i++)
                    if (list_mem[i] == r.value)
                        o.found = 1'b1;
            default: ;
        endcase
        o.count    = CNT_W'(list_len);
        o.is_empty = (list_len == 0);
        return o;
    endfunction

    function automatic dir_row_t chk_row(logic [2:0] act, logic [IDX_W-1:0] idx,
                                         logic [DATA_W-1:0] val, logic [1:0] st,
                                         logic [DATA_W-1:0] rd, logic fnd, int cnt);
        dir_row_t d;
        d.req.action       = act;
        d.req.index        = idx;
        d.req.value        = val;
        d.typed            = 1'b1;
        d.exp.status       = st;
        d.exp.read_value   = rd;
        d.exp.found        = fnd;
        d.exp.count        = CNT_W'(cnt);
        d.exp.is_empty     = (cnt == 0);
        return d;
    endfunction

    function automatic dir_row_t pred_row(logic [2:0] act, logic [IDX_W-1:0] idx,
                                          logic [DATA_W-1:0] val);
        dir_row_t d;
        d.req.action = act;
        d.req.index  = idx;
        d.req.value  = val;
        d.typed      = 1'b0;
        d.exp        = '0;
        return d;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (list_len > 0 && r < 80)
            return IDX_W'($urandom_range(0, list_len - 1));
        else if (r < 90 && list_len < CAPACITY)
            return IDX_W'(list_len);
        else
            return IDX_W'($urandom_range(0, CAPACITY - 1));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(bit want_hit);
        int r;
        r = $urandom_range(0, 99);
        if (want_hit && list_len > 0 && r < 50)
            return list_mem[$urandom_range(0, list_len - 1)];
        case (r % 16)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t random_req(traffic_mode_t mode);
        req_t r;
        int   p;
        p = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
                r.action = p < 70 ? ACT_APPEND : p < 85 ? ACT_INSERT : p < 89 ? ACT_GET :
                           p < 93 ? ACT_SET : p < 98 ? ACT_CONTAINS : p < 99 ? ACT_REMOVE :
                           ACT_SPARE_A;
            MODE_FULL:
                r.action = p < 40 ? ACT_APPEND : p < 65 ? ACT_INSERT : p < 75 ? ACT_GET :
                           p < 85 ? ACT_SET : p < 95 ? ACT_CONTAINS : p < 97 ? ACT_REMOVE :
                           ACT_SPARE_B;
            MODE_SHRINK:
                r.action = p < 75 ? ACT_REMOVE : p < 80 ? ACT_APPEND : p < 85 ? ACT_GET :
                           p < 90 ? ACT_SET : p < 97 ? ACT_CONTAINS : ACT_SPARE_A;
            default:
                r.action = p < 22 ? ACT_APPEND : p < 38 ? ACT_INSERT : p < 62 ? ACT_REMOVE :
                           p < 72 ? ACT_GET : p < 82 ? ACT_SET : p < 96 ? ACT_CONTAINS :
                           ($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B);
        endcase
        r.index = pick_index();
        r.value = pick_value(r.action == ACT_CONTAINS);
        return r;
    endfunction

    // bursts of requests with random gaps, sometimes long runs with none
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(20, 60);
                gap        = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 10);
                gap        = $urandom_range(0, 7) == 0 ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
            end
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_req(req_t r, bit typed, rsp_t typed_exp);
        rsp_t pred;
        pace_sender();
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        // request taken at this edge
        pred = predict_list(r);
        expected_rsp.push_back(typed ? typed_exp : pred);
    endtask

    task automatic check_rsp(rsp_t exp, rsp_t got);
        string bad;
        bad = "";
        if (got.status !== exp.status)         bad = {bad, " status"};
        if (got.read_value !== exp.read_value) bad = {bad, " read_value"};
        if (got.found !== exp.found)           bad = {bad, " found"};
        if (got.count !== exp.count)           bad = {bad, " count"};
        if (got.is_empty !== exp.is_empty)     bad = {bad, " is_empty"};
        if (bad != "")
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("mismatch on%s: exp st=%0d rd=%0d fnd=%0b cnt=%0d emp=%0b,",
                         bad, exp.status, exp.read_value, exp.found, exp.count,
                         exp.is_empty);
                $display("    got st=%0d rd=%0d fnd=%0b cnt=%0d emp=%0b",
                         got.status, got.read_value, got.found, got.count, got.is_empty);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: st=%0d rd=%0d fnd=%0b cnt=%0d emp=%0b",
                                 rsp.status, rsp.read_value, rsp.found, rsp.count, rsp.is_empty);
                end
                else
                    check_rsp(expected_rsp.pop_front(), rsp);
            end
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        fail_count   = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        list_len     = 0;
        for (k = 0; k < CAPACITY; k++)
            list_mem[k] = '0;

        // empty list: every positioned action is out of range
        dir_tab.push_back(chk_row(ACT_GET,      0,   0,            STAT_BAD_INDEX, '1, 0, 0));
        dir_tab.push_back(chk_row(ACT_REMOVE,   0,   0,            STAT_BAD_INDEX, 0,  0, 0));
        dir_tab.push_back(chk_row(ACT_SET,      0,   5,            STAT_BAD_INDEX, 0,  0, 0));
        dir_tab.push_back(chk_row(ACT_INSERT,   0,   7,            STAT_BAD_INDEX, 0,  0, 0));
        dir_tab.push_back(chk_row(ACT_CONTAINS, 0,   0,            STAT_OK,        0,  0, 0));
        dir_tab.push_back(chk_row(ACT_SPARE_A,  255, 32'hFFFF_FFFF, STAT_OK,       0,  0, 0));
        dir_tab.push_back(chk_row(ACT_SPARE_B,  0,   32'h7FFF_FFFF, STAT_OK,       0,  0, 0));
        dir_tab.push_back(chk_row(ACT_APPEND,   0,   32'h8000_0000, STAT_OK,       0,  0, 1));
        dir_tab.push_back(chk_row(ACT_APPEND,   255, 32'h7FFF_FFFF, STAT_OK,       0,  0, 2));
        dir_tab.push_back(chk_row(ACT_GET,      0,   0, STAT_OK, 32'h8000_0000, 0, 2));
        dir_tab.push_back(chk_row(ACT_GET,      1,   0, STAT_OK, 32'h7FFF_FFFF, 0, 2));
        dir_tab.push_back(chk_row(ACT_GET,      2,   0,            STAT_BAD_INDEX, '1, 0, 2));
        // insert at the count itself is out of range
        dir_tab.push_back(chk_row(ACT_INSERT,   2,   9,            STAT_BAD_INDEX, 0,  0, 2));
        dir_tab.push_back(pred_row(ACT_INSERT,  0,   32'hFFFF_FFFF));
        dir_tab.push_back(pred_row(ACT_CONTAINS, 0,  32'hFFFF_FFFF));
        dir_tab.push_back(pred_row(ACT_CONTAINS, 0,  32'h0000_0000));
        dir_tab.push_back(chk_row(ACT_SET,      255, 1,            STAT_BAD_INDEX, 0,  0, 3));
        dir_tab.push_back(pred_row(ACT_SET,     1,   32'h0000_0000));
        dir_tab.push_back(pred_row(ACT_CONTAINS, 0,  32'h8000_0000));
        dir_tab.push_back(pred_row(ACT_REMOVE,  0,   0));
        dir_tab.push_back(chk_row(ACT_REMOVE,   255, 0,            STAT_BAD_INDEX, 0,  0, 2));
        dir_tab.push_back(chk_row(ACT_GET,      255, 0,            STAT_BAD_INDEX, '1, 0, 2));
        dir_tab.push_back(pred_row(ACT_REMOVE,  1,   0));
        dir_tab.push_back(pred_row(ACT_REMOVE,  0,   0));
        // stale words past the count must not match
        dir_tab.push_back(chk_row(ACT_CONTAINS, 0,   32'h7FFF_FFFF, STAT_OK,       0,  0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
            send_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].exp);

        repeat (40) send_req(random_req(MODE_MIX), 1'b0, '0);
        while (list_len < CAPACITY)
            send_req(random_req(MODE_GROW), 1'b0, '0);
        repeat (25) send_req(random_req(MODE_FULL), 1'b0, '0);
        repeat (40) send_req(random_req(MODE_SHRINK), 1'b0, '0);

        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
